>>> rtl/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants for the software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int ID_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam int KIND_W     = 3;
    localparam int TID_W      = 4;
    localparam int INTV_W     = 32;
    localparam int ELAPSED_W  = 16;
    localparam int REM_W      = 34;
    localparam int STATUS_W   = 2;

    localparam logic [INTV_W-1:0] MIN_INTERVAL_RST = INTV_W'(1);

    typedef enum logic [KIND_W-1:0] {
        K_START   = 3'd0,
        K_DESTROY = 3'd1,
        K_UPDATE  = 3'd2,
        K_QTICKED = 3'd3,
        K_QACTIVE = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_IN_USE  = 2'd2,
        ST_UNKNOWN = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_DONE
    } state_t;

    // One table word; remaining is a two's complement count.
    typedef struct packed {
        logic              auto_free;
        logic [INTV_W-1:0] interval;
        logic [REM_W-1:0]  remaining;
    } entry_t;

    typedef struct packed {
        logic             expired;
        logic [REM_W-1:0] remaining;
    } sweep_res_t;

endpackage

>>> rtl/stb_ram.sv
// ----------------------------------------------------------------------------
// stb_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stb_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/stb_sweep_alu.sv
// ----------------------------------------------------------------------------
// stb_sweep_alu
// Per-entry update: subtract elapsed time, reload once on expiry, saturate.
// ----------------------------------------------------------------------------
module stb_sweep_alu (
    input  stb_pkg::entry_t                   entry,
    input  logic [stb_pkg::ELAPSED_W-1:0]     elapsed,
    output stb_pkg::sweep_res_t               res
);

    localparam int SUM_W = stb_pkg::REM_W + 1;

    logic [SUM_W-1:0] diff;
    logic [SUM_W-1:0] wrapped;
    logic [SUM_W-1:0] sel;

    always_comb begin
        diff    = {entry.remaining[stb_pkg::REM_W-1], entry.remaining}
                  - SUM_W'(elapsed);
        wrapped = diff + SUM_W'(entry.interval);
        sel     = diff[SUM_W-1] ? wrapped : diff;
        res.expired = diff[SUM_W-1];
        // below the 34-bit floor when the top two bits read 10
        if (sel[SUM_W-1] && !sel[SUM_W-2]) begin
            res.remaining = {1'b1, (stb_pkg::REM_W-1)'(0)};
        end else begin
            res.remaining = sel[stb_pkg::REM_W-1:0];
        end
    end

endmodule

>>> rtl/software_timer_bank_core.sv
// ----------------------------------------------------------------------------
// software_timer_bank_core
// Bank of one-shot and periodic timers, one table entry per timer id.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_valid/s_ready with kind, timer_id, interval_ms,
//   auto_free (one-shot mode) and elapsed_ms. Each item returns exactly one
//   result item on m_valid/m_ready carrying status, ticked and active.
//   min_interval is written through cfg_wr_en/cfg_wr_data while idle; it
//   resets to 1.
// Timing:
//   One item is in flight at a time. Start, destroy and the queries pass
//   through the execute state and the holding stage to the output register.
//   An update sweeps the timer table through its read port, one entry per
//   cycle, then passes through the holding stage. s_ready rises at the same
//   edge that loads the result into the output register.
// Reset (aresetn low, synchronous): all timers invalid, no ticked marks,
//   no result pending. The table RAM itself is not cleared; an entry is only
//   used after a start has written it.
// Stall: a finished result waits in a holding stage until the output
//   register is free; no new item is taken meanwhile.
// ----------------------------------------------------------------------------
module software_timer_bank_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [stb_pkg::INTV_W-1:0]          cfg_wr_data,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [stb_pkg::KIND_W-1:0]          s_kind,
    input  logic [stb_pkg::TID_W-1:0]           s_timer_id,
    input  logic [stb_pkg::INTV_W-1:0]          s_interval_ms,
    input  logic                                s_auto_free,
    input  logic [stb_pkg::ELAPSED_W-1:0]       s_elapsed_ms,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [stb_pkg::STATUS_W-1:0]        m_status,
    output logic                                m_ticked,
    output logic                                m_active
);

    localparam int ID_W = stb_pkg::ID_W;
    localparam int NT   = stb_pkg::NUM_TIMERS;
    localparam logic [ID_W-1:0] LAST_IDX = ID_W'(NT - 1);

    // ---------------- state ----------------
    stb_pkg::state_t state_reg, state_next;

    logic [stb_pkg::INTV_W-1:0]    min_interval_reg;
    logic [NT-1:0]                 valid_reg;
    logic [NT-1:0]                 ticked_reg;
    logic [ID_W-1:0]               sweep_idx_reg;

    // latched item payload
    stb_pkg::kind_t                item_kind_reg;
    logic [stb_pkg::TID_W-1:0]     item_id_reg;
    logic [stb_pkg::INTV_W-1:0]    item_interval_reg;
    logic                          item_auto_free_reg;
    logic [stb_pkg::ELAPSED_W-1:0] item_elapsed_reg;

    // holding stage between execution and the output register
    stb_pkg::status_t              res_status_reg;
    logic                          res_ticked_reg;
    logic                          res_active_reg;

    logic                          m_valid_reg;
    stb_pkg::status_t              m_status_reg;
    logic                          m_ticked_reg;
    logic                          m_active_reg;

    // ---------------- table RAM ----------------
    logic                          ram_wr_en;
    logic [ID_W-1:0]               ram_wr_addr;
    stb_pkg::entry_t               ram_wr_data;
    logic [ID_W-1:0]               ram_rd_addr;
    stb_pkg::entry_t               ram_rd_data;

    stb_ram #(
        .DEPTH (NT),
        .WIDTH ($bits(stb_pkg::entry_t))
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    stb_pkg::sweep_res_t sweep_res;

    stb_sweep_alu u_alu (
        .entry   (ram_rd_data),
        .elapsed (item_elapsed_reg),
        .res     (sweep_res)
    );

    // ---------------- item decode ----------------
    logic [ID_W-1:0]   id_idx;
    logic              in_table;
    logic              id_valid;
    logic              start_ok;
    logic              destroy_ok;
    logic              query_hit;
    stb_pkg::status_t  exec_status;
    logic              exec_ticked;
    logic              exec_active;
    logic              accept;
    logic              out_free;
    logic              sweep_last;

    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign sweep_last = (sweep_idx_reg == LAST_IDX);
    assign id_idx     = ID_W'(item_id_reg);
    assign in_table   = (32'(item_id_reg) < 32'(NT));
    assign id_valid   = in_table && valid_reg[id_idx];

    // Work out the answer of a non-update item; the query read lands now.
    always_comb begin
        start_ok    = 1'b0;
        destroy_ok  = 1'b0;
        query_hit   = 1'b0;
        exec_status = stb_pkg::ST_OK;
        exec_ticked = 1'b0;
        exec_active = 1'b0;
        unique case (item_kind_reg)
            stb_pkg::K_START: begin
                if (item_interval_reg < min_interval_reg) begin
                    exec_status = stb_pkg::ST_SHORT;
                end else if (!in_table) begin
                    exec_status = stb_pkg::ST_UNKNOWN;
                end else if (valid_reg[id_idx]) begin
                    exec_status = stb_pkg::ST_IN_USE;
                end else begin
                    start_ok = 1'b1;
                end
            end
            stb_pkg::K_DESTROY: begin
                if (!id_valid) begin
                    exec_status = stb_pkg::ST_UNKNOWN;
                end else begin
                    destroy_ok = 1'b1;
                end
            end
            stb_pkg::K_QTICKED: begin
                if (!id_valid) begin
                    exec_status = stb_pkg::ST_UNKNOWN;
                end else if (ticked_reg[id_idx]) begin
                    query_hit   = 1'b1;
                    exec_ticked = 1'b1;
                end
            end
            stb_pkg::K_QACTIVE: begin
                exec_active = id_valid;
            end
            default: begin
                // update never reaches execution; unused kinds answer ok
            end
        endcase
    end

    // ---------------- FSM: next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            stb_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_kind == stb_pkg::K_UPDATE) ? stb_pkg::S_SWEEP
                                                                : stb_pkg::S_EXEC;
                end
            end
            stb_pkg::S_EXEC:  state_next = stb_pkg::S_DONE;
            stb_pkg::S_SWEEP: begin
                if (sweep_last) begin
                    state_next = stb_pkg::S_DONE;
                end
            end
            stb_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = stb_pkg::S_IDLE;
                end
            end
            default: state_next = stb_pkg::S_IDLE;
        endcase
    end

    // ---------------- FSM: outputs ----------------
    always_comb begin
        s_ready     = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = id_idx;
        ram_wr_data = '{auto_free: item_auto_free_reg,
                        interval:  item_interval_reg,
                        remaining: stb_pkg::REM_W'(item_interval_reg)};
        ram_rd_addr = sweep_idx_reg;
        unique case (state_reg)
            stb_pkg::S_IDLE: begin
                s_ready = 1'b1;
                // start the sweep at entry 0, otherwise fetch the addressed entry
                ram_rd_addr = (s_kind == stb_pkg::K_UPDATE) ? '0 : ID_W'(s_timer_id);
            end
            stb_pkg::S_EXEC: begin
                ram_wr_en = start_ok;
            end
            stb_pkg::S_SWEEP: begin
                // read one entry ahead while writing back the current one
                ram_rd_addr = ID_W'(sweep_idx_reg + ID_W'(1));
                ram_wr_addr = sweep_idx_reg;
                ram_wr_en   = valid_reg[sweep_idx_reg];
                ram_wr_data = '{auto_free: ram_rd_data.auto_free,
                                interval:  ram_rd_data.interval,
                                remaining: sweep_res.remaining};
            end
            stb_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= stb_pkg::S_IDLE;
            min_interval_reg <= stb_pkg::MIN_INTERVAL_RST;
            valid_reg        <= '0;
            ticked_reg       <= '0;
            sweep_idx_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                min_interval_reg <= cfg_wr_data;
            end

            if (accept) begin
                sweep_idx_reg <= '0;
            end else if (state_reg == stb_pkg::S_SWEEP) begin
                sweep_idx_reg <= ID_W'(sweep_idx_reg + ID_W'(1));
            end

            if (state_reg == stb_pkg::S_EXEC) begin
                if (start_ok) begin
                    valid_reg[id_idx]  <= 1'b1;
                    ticked_reg[id_idx] <= 1'b0;
                end
                if (destroy_ok) begin
                    valid_reg[id_idx]  <= 1'b0;
                    ticked_reg[id_idx] <= 1'b0;
                end
                if (query_hit) begin
                    ticked_reg[id_idx] <= 1'b0;
                    // free a one-shot timer once its tick is reported
                    if (ram_rd_data.auto_free) begin
                        valid_reg[id_idx] <= 1'b0;
                    end
                end
            end

            if (state_reg == stb_pkg::S_SWEEP &&
                valid_reg[sweep_idx_reg] && sweep_res.expired) begin
                ticked_reg[sweep_idx_reg] <= 1'b1;
            end

            if (state_reg == stb_pkg::S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload: latch the item, the pending answer and the output word
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_kind_reg      <= stb_pkg::kind_t'(s_kind);
            item_id_reg        <= s_timer_id;
            item_interval_reg  <= s_interval_ms;
            item_auto_free_reg <= s_auto_free;
            item_elapsed_reg   <= s_elapsed_ms;
        end
        if (state_reg == stb_pkg::S_EXEC) begin
            res_status_reg <= exec_status;
            res_ticked_reg <= exec_ticked;
            res_active_reg <= exec_active;
        end else if (state_reg == stb_pkg::S_SWEEP) begin
            res_status_reg <= stb_pkg::ST_OK;
            res_ticked_reg <= 1'b0;
            res_active_reg <= 1'b0;
        end
        if (state_reg == stb_pkg::S_DONE && out_free) begin
            m_status_reg <= res_status_reg;
            m_ticked_reg <= res_ticked_reg;
            m_active_reg <= res_active_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_ticked = m_ticked_reg;
    assign m_active = m_active_reg;

    // ---------------- assertions ----------------
    // a ticked mark only ever sits on a running timer
    a_ticked_on_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (ticked_reg & ~valid_reg) == '0)
        else $error("ticked mark on an inactive timer");

    // the sweep ends right after the last entry
    a_sweep_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == stb_pkg::S_SWEEP && sweep_last) |=> (state_reg == stb_pkg::S_DONE))
        else $error("sweep did not finish after the last entry");

    // a new result only appears out of the holding stage
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == stb_pkg::S_DONE))
        else $error("result appeared without a finished item");

    // no item is taken while one is still in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second item accepted while busy");

endmodule

>>> bench/software_timer_bank_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// software_timer_bank_core_test
// Self-checking bench for the timer bank: drives start, destroy, update and
// query items, predicts every answer from a private copy of the timer table,
// and checks each result item field by field under random idling and stalls.
// ----------------------------------------------------------------------------
module software_timer_bank_core_test;

    // Run limit, far beyond the slowest correct run.
    localparam int     TIMEOUT_NS   = 5_000_000;
    // Settle time at the end: one full update sweep plus margin.
    localparam int     DRAIN_CYCLES = stb_pkg::NUM_TIMERS + 8;
    // Lowest value of the 34-bit remaining count.
    localparam longint REMAIN_FLOOR = -(longint'(1) << (stb_pkg::REM_W - 1));

    typedef struct {
        stb_pkg::status_t status;
        logic             ticked;
        logic             active;
    } answer_t;

    // Clock and reset
    logic aclk;
    logic aresetn = 1'b0;

    // Configuration port
    logic                       cfg_wr_en   = 1'b0;
    logic [stb_pkg::INTV_W-1:0] cfg_wr_data = '0;

    // Input channel
    logic                          s_valid       = 1'b0;
    logic                          s_ready;
    logic [stb_pkg::KIND_W-1:0]    s_kind        = '0;
    logic [stb_pkg::TID_W-1:0]     s_timer_id    = '0;
    logic [stb_pkg::INTV_W-1:0]    s_interval_ms = '0;
    logic                          s_auto_free   = 1'b0;
    logic [stb_pkg::ELAPSED_W-1:0] s_elapsed_ms  = '0;

    // Result channel
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [stb_pkg::STATUS_W-1:0] m_status;
    logic                         m_ticked;
    logic                         m_active;

    // Private copy of the timer table and the min_interval register
    bit                       tmr_valid     [stb_pkg::NUM_TIMERS];
    bit                       tmr_auto_free [stb_pkg::NUM_TIMERS];
    bit [stb_pkg::INTV_W-1:0] tmr_interval  [stb_pkg::NUM_TIMERS];
    longint                   tmr_remaining [stb_pkg::NUM_TIMERS];
    bit                       tmr_ticked    [stb_pkg::NUM_TIMERS];
    bit [stb_pkg::INTV_W-1:0] min_interval_q = stb_pkg::MIN_INTERVAL_RST;

    // Answers still owed by the block, oldest first
    answer_t expected_answers[$];

    int fail_count      = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_off_cycles = 0;

    software_timer_bank_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_timer_id    (s_timer_id),
        .s_interval_ms (s_interval_ms),
        .s_auto_free   (s_auto_free),
        .s_elapsed_ms  (s_elapsed_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_ticked      (m_ticked),
        .m_active      (m_active)
    );

    // 10 ns period: low half, then high half
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Timer table prediction: apply one item to the private table and return
    // the answer the block must give for it.
    // ------------------------------------------------------------------------
    function automatic answer_t predict_timer_item(
        logic [stb_pkg::KIND_W-1:0]    kind,
        logic [stb_pkg::TID_W-1:0]     id,
        logic [stb_pkg::INTV_W-1:0]    interval,
        logic                          auto_free,
        logic [stb_pkg::ELAPSED_W-1:0] elapsed
    );
        answer_t ans;
        bit      in_table;
        bit      known;
        longint  rem;
        ans      = '{stb_pkg::ST_OK, 1'b0, 1'b0};
        in_table = int'(id) < stb_pkg::NUM_TIMERS;
        known    = in_table && tmr_valid[id];
        case (kind)
            stb_pkg::K_START: begin
                // Interval check wins over every id check.
                if (interval < min_interval_q) begin
                    ans.status = stb_pkg::ST_SHORT;
                end else if (!in_table) begin
                    ans.status = stb_pkg::ST_UNKNOWN;
                end else if (tmr_valid[id]) begin
                    ans.status = stb_pkg::ST_IN_USE;
                end else begin
                    tmr_valid[id]     = 1'b1;
                    tmr_auto_free[id] = auto_free;
                    tmr_interval[id]  = interval;
                    tmr_remaining[id] = longint'(interval);
                    tmr_ticked[id]    = 1'b0;
                end
            end
            stb_pkg::K_DESTROY: begin
                if (!known) begin
                    ans.status = stb_pkg::ST_UNKNOWN;
                end else begin
                    tmr_valid[id]  = 1'b0;
                    tmr_ticked[id] = 1'b0;
                end
            end
            stb_pkg::K_UPDATE: begin
                // Add the interval back once at most, then clamp at the floor.
                for (int i = 0; i < stb_pkg::NUM_TIMERS; i++) begin
                    if (tmr_valid[i]) begin
                        rem = tmr_remaining[i] - longint'(elapsed);
                        if (rem < 0) begin
                            rem += longint'(tmr_interval[i]);
                            tmr_ticked[i] = 1'b1;
                        end
                        if (rem < REMAIN_FLOOR) begin
                            rem = REMAIN_FLOOR;
                        end
                        tmr_remaining[i] = rem;
                    end
                end
            end
            stb_pkg::K_QTICKED: begin
                if (!known) begin
                    ans.status = stb_pkg::ST_UNKNOWN;
                end else if (tmr_ticked[id]) begin
                    ans.ticked     = 1'b1;
                    tmr_ticked[id] = 1'b0;
                    // A one-shot timer is spent once its tick is read.
                    if (tmr_auto_free[id]) begin
                        tmr_valid[id] = 1'b0;
                    end
                end
            end
            stb_pkg::K_QACTIVE: begin
                ans.active = known;
            end
            default: begin
                // Unused kinds leave the table alone.
            end
        endcase
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Offer one item, optionally after random idle cycles, and hold it until
    // accepted. Valid stays high afterwards so back-to-back items need no
    // extra edge; it is lowered only when idling or draining.
    // ------------------------------------------------------------------------
    task automatic send_item(
        logic [stb_pkg::KIND_W-1:0]    kind,
        logic [stb_pkg::TID_W-1:0]     id,
        logic [stb_pkg::INTV_W-1:0]    interval,
        logic                          auto_free,
        logic [stb_pkg::ELAPSED_W-1:0] elapsed
    );
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_kind        <= kind;
        s_timer_id    <= id;
        s_interval_ms <= interval;
        s_auto_free   <= auto_free;
        s_elapsed_ms  <= elapsed;
        do
            @(posedge aclk);
        while (!s_ready);
        // Accepted at this edge: predict in acceptance order.
        expected_answers.push_back(
            predict_timer_item(kind, id, interval, auto_free, elapsed));
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic wait_for_idle();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (expected_answers.size() != 0);
    endtask

    // Write min_interval with the block idle.
    task automatic write_min_interval(logic [stb_pkg::INTV_W-1:0] value);
        wait_for_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        min_interval_q  = value;
    endtask

    // ------------------------------------------------------------------------
    // Random item, biased toward starts, updates and ticked queries so timers
    // actually arm, expire and get read; intervals hug min_interval and
    // elapsed times are mostly comparable to the intervals.
    // ------------------------------------------------------------------------
    task automatic send_random_item();
        logic [stb_pkg::KIND_W-1:0]    kind;
        logic [stb_pkg::INTV_W-1:0]    interval;
        logic [stb_pkg::ELAPSED_W-1:0] elapsed;
        int                            pick;
        pick = $urandom_range(99);
        if (pick < 30) begin
            kind = stb_pkg::K_START;
        end else if (pick < 40) begin
            kind = stb_pkg::K_DESTROY;
        end else if (pick < 65) begin
            kind = stb_pkg::K_UPDATE;
        end else if (pick < 85) begin
            kind = stb_pkg::K_QTICKED;
        end else if (pick < 95) begin
            kind = stb_pkg::K_QACTIVE;
        end else begin
            kind = stb_pkg::KIND_W'($urandom_range((1 << stb_pkg::KIND_W) - 1,
                                                   int'(stb_pkg::K_QACTIVE) + 1));
        end
        case ($urandom_range(9))
            0:       interval = $urandom();
            1:       interval = min_interval_q;
            2:       interval = min_interval_q - 1;
            default: interval = min_interval_q + $urandom_range(3000);
        endcase
        case ($urandom_range(9))
            0:       elapsed = stb_pkg::ELAPSED_W'($urandom());
            1:       elapsed = '1;
            2:       elapsed = '0;
            default: elapsed = stb_pkg::ELAPSED_W'($urandom_range(4000));
        endcase
        send_item(kind, stb_pkg::TID_W'($urandom_range(stb_pkg::NUM_TIMERS - 1)),
                  interval, 1'($urandom_range(1)), elapsed);
    endtask

    // ------------------------------------------------------------------------
    // Result check: compare each accepted result with the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_answers.size() == 0) begin
                $error("result item with no expectation waiting: status %0d", m_status);
                fail_count++;
            end else begin
                want = expected_answers.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_status);
                    fail_count++;
                end
                if (m_ticked !== want.ticked) begin
                    $error("ticked: expected %0d, actual %0d", want.ticked, m_ticked);
                    fail_count++;
                end
                if (m_active !== want.active) begin
                    $error("active: expected %0d, actual %0d", want.active, m_active);
                    fail_count++;
                end
            end
        end
    end

    // Receiver: long hold-off first, else a random stall.
    always @(posedge aclk) begin : ready_drive
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // Nothing is armed after reset.
    task automatic test_reset_state();
        send_item(stb_pkg::K_QACTIVE, '0, '0, 1'b0, '0);
        send_item(stb_pkg::K_QTICKED, '1, '1, 1'b1, '1);
    endtask

    // Start rejections in their order, destroy of a live and a dead id.
    task automatic test_start_checks();
        send_item(stb_pkg::K_START,   4'd3, '0,     1'b0, '0);  // below min_interval
        send_item(stb_pkg::K_START,   4'd3, 32'd10, 1'b0, '0);
        send_item(stb_pkg::K_START,   4'd3, 32'd20, 1'b1, '0);  // id in use
        send_item(stb_pkg::K_START,   4'd3, '0,     1'b1, '0);  // short beats in use
        send_item(stb_pkg::K_DESTROY, 4'd3, '0,     1'b0, '0);
        send_item(stb_pkg::K_DESTROY, 4'd3, '0,     1'b0, '0);  // unknown id
    endtask

    // One-shot frees itself on a read tick, periodic keeps running.
    task automatic test_one_shot_and_periodic();
        send_item(stb_pkg::K_START,   '0, 32'd5, 1'b1, '0);
        send_item(stb_pkg::K_START,   '1, '1,    1'b0, '0);
        send_item(stb_pkg::K_UPDATE,  '0, '0,    1'b0, 16'd6);
        send_item(stb_pkg::K_UPDATE,  '0, '0,    1'b0, '1);
        send_item(stb_pkg::K_QTICKED, '0, '0,    1'b0, '0);
        send_item(stb_pkg::K_QACTIVE, '0, '0,    1'b0, '0);
        send_item(stb_pkg::K_QTICKED, '0, '0,    1'b0, '0);     // freed, now unknown
        send_item(stb_pkg::K_QTICKED, '1, '0,    1'b0, '0);
        send_item(stb_pkg::K_QACTIVE, '1, '0,    1'b0, '0);
        send_item(stb_pkg::K_DESTROY, '1, '0,    1'b0, '0);
    endtask

    // Kinds past query-active answer all zeros and touch nothing.
    task automatic test_unused_kinds();
        for (int k = int'(stb_pkg::K_QACTIVE) + 1; k < (1 << stb_pkg::KIND_W); k++) begin
            send_item(stb_pkg::KIND_W'(k), '1, '1, 1'b1, '1);
        end
    endtask

    // Both extremes of min_interval, including a zero interval that stays
    // negative and ticks on every update.
    task automatic test_min_interval_extremes();
        write_min_interval('1);
        send_item(stb_pkg::K_START, 4'd7, 32'hFFFF_FFFE, 1'b0, '0);
        send_item(stb_pkg::K_START, 4'd7, '1,            1'b0, '0);
        write_min_interval('0);
        send_item(stb_pkg::K_START,   4'd8, '0, 1'b0, '0);
        send_item(stb_pkg::K_UPDATE,  '0,   '0, 1'b0, 16'd100);
        send_item(stb_pkg::K_QTICKED, 4'd8, '0, 1'b0, '0);
        send_item(stb_pkg::K_DESTROY, 4'd7, '0, 1'b0, '0);
        send_item(stb_pkg::K_DESTROY, 4'd8, '0, 1'b0, '0);
    endtask

    // Hold the result side off for a long stretch while items keep coming,
    // so the block fills up and stalls its input.
    task automatic test_backpressure();
        wait_for_idle();
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 300;
        repeat (12) begin
            send_random_item();
        end
    endtask

    task automatic test_random_traffic(int num_items, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (num_items) begin
            send_random_item();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_start_checks();
        test_one_shot_and_periodic();
        test_unused_kinds();
        test_min_interval_extremes();

        write_min_interval(32'd1);
        test_backpressure();

        // Random phases, each under its own min_interval and idling mix.
        write_min_interval(32'd1);
        test_random_traffic(150, 0, 0);
        write_min_interval(32'd0);
        test_random_traffic(150, 54, 0);
        write_min_interval(32'd500);
        test_random_traffic(150, 0, 54);
        write_min_interval(32'd37);
        test_random_traffic(160, 32, 32);

        // Drain, let a full sweep's worth of cycles pass, then report.
        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Hard stop if the run hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/stb_pkg.sv
rtl/stb_ram.sv
rtl/stb_sweep_alu.sv
rtl/software_timer_bank_core.sv
bench/software_timer_bank_core_test.sv
